### rtl/bit_field_copy_engine_macros.svh
// Assertion macros shared by the bit field copy engine RTL.
`ifndef BIT_FIELD_COPY_ENGINE_MACROS_SVH
`define BIT_FIELD_COPY_ENGINE_MACROS_SVH
`ifndef SYNTH
`define BFCE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfce check failed");
`define BFCE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfce check failed");
`else
`define BFCE_ASSERT_NOW(label, ante, cons)
`define BFCE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/bfce_pkg.sv
// Types, codes and helpers shared by the bit field copy engine.
package bfce_pkg;

	localparam logic [1:0] MODE_SRC = 2'd0;
	localparam logic [1:0] MODE_DST = 2'd1;
	localparam logic [1:0] MODE_RUN = 2'd2;

	localparam int unsigned MAX_EMIT = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_ERR
	} state_t;

	// Byte that holds a buffer bit, for either byte order.
	function automatic logic [5:0] byte_pos(input logic [7:0] pos, input logic [5:0] len,
			input logic big);
		logic [5:0] b;
		b = {1'b0, pos[7:3]};
		return big ? (len - 6'd1 - b) : b;
	endfunction

endpackage

### rtl/bfce_store.sv
// Byte store with one write port and one registered read port.
module bfce_store
	import bfce_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/bit_field_copy_engine.sv
// Top level of the bit field copy engine: sequencer, bit datapath and two byte stores.
// Load transactions never raise busy.
// In a run, each copied bit is a read-modify-write through the single read and write port
// of each store, each emitted byte a read then a result.
// A refused run gives its error result in the cycle after acceptance and then drops busy.
// Results cannot be stalled. Reset clears the sequencer only; store contents are kept.
`include "bit_field_copy_engine_macros.svh"
module bit_field_copy_engine
	import bfce_pkg::*;
#(
	parameter int BUF_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [4:0] byte_index,
	input  logic [7:0] byte_value,
	input  logic [8:0] bit_count,
	input  logic [7:0] dst_bit_offset,
	input  logic [7:0] src_bit_offset,
	input  logic       big_endian,
	input  logic [5:0] dst_length,
	input  logic [5:0] src_length,
	output logic       strobe,
	output logic [4:0] out_index,
	output logic [7:0] out_value,
	output logic       last,
	output logic       error
);

	localparam int ADDR_W = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
	localparam int MAX_LEN = (BUF_BYTES < MAX_EMIT) ? BUF_BYTES : MAX_EMIT;

	state_t state_q, state_d;

	logic [8:0] src_pos_q, dst_pos_q, rem_q;
	logic       big_q;
	logic [5:0] dst_len_q, src_len_q;
	logic [4:0] emit_q;

	logic accept, load_ok, len_bad, src_over, dst_over, run_bad;
	logic [ADDR_W-1:0] src_raddr, dst_addr, dst_waddr, dst_raddr;
	logic [7:0] src_rdata, dst_rdata, merged, dst_wdata;
	logic src_we, dst_we, emit_last;

	assign accept = start && !busy;
	assign load_ok = 32'(byte_index) < BUF_BYTES;

	assign len_bad = (dst_length == 6'd0) || (src_length == 6'd0) ||
		(32'(dst_length) > MAX_LEN) || (32'(src_length) > MAX_LEN);
	assign src_over = (10'(src_bit_offset) + 10'(bit_count)) > {1'b0, src_length, 3'b000};
	assign dst_over = (10'(dst_bit_offset) + 10'(bit_count)) > {1'b0, dst_length, 3'b000};
	assign run_bad = len_bad || src_over || dst_over;

	assign src_raddr = ADDR_W'(byte_pos(src_pos_q[7:0], src_len_q, big_q));
	assign dst_addr = ADDR_W'(byte_pos(dst_pos_q[7:0], dst_len_q, big_q));

	always_comb begin
		merged = dst_rdata;
		merged[dst_pos_q[2:0]] = src_rdata[src_pos_q[2:0]];
	end

	assign src_we = accept && (mode == MODE_SRC) && load_ok;
	assign dst_we = (accept && (mode == MODE_DST) && load_ok) || (state_q == ST_COPY_WR);
	assign dst_waddr = (state_q == ST_COPY_WR) ? dst_addr : ADDR_W'(byte_index);
	assign dst_wdata = (state_q == ST_COPY_WR) ? merged : byte_value;
	assign dst_raddr = (state_q == ST_EMIT_RD) ? ADDR_W'(emit_q) : dst_addr;

	bfce_store #(.DEPTH(BUF_BYTES), .ADDR_W(ADDR_W)) u_src_store (
		.clk   (clk),
		.we    (src_we),
		.waddr (ADDR_W'(byte_index)),
		.wdata (byte_value),
		.raddr (src_raddr),
		.rdata (src_rdata)
	);

	bfce_store #(.DEPTH(BUF_BYTES), .ADDR_W(ADDR_W)) u_dst_store (
		.clk   (clk),
		.we    (dst_we),
		.waddr (dst_waddr),
		.wdata (dst_wdata),
		.raddr (dst_raddr),
		.rdata (dst_rdata)
	);

	assign emit_last = (6'(emit_q) + 6'd1) == dst_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy = 1'b1;
		strobe = 1'b0;
		error = 1'b0;
		last = 1'b0;
		out_index = emit_q;
		out_value = dst_rdata;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start && (mode == MODE_RUN)) begin
					if (run_bad) begin
						state_d = ST_ERR;
					end else if (bit_count == 9'd0) begin
						state_d = ST_EMIT_RD;
					end else begin
						state_d = ST_COPY_RD;
					end
				end
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				state_d = (rem_q == 9'd1) ? ST_EMIT_RD : ST_COPY_RD;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				strobe = 1'b1;
				last = emit_last;
				state_d = emit_last ? ST_IDLE : ST_EMIT_RD;
			end
			ST_ERR: begin
				strobe = 1'b1;
				error = 1'b1;
				last = 1'b1;
				out_index = 5'd0;
				out_value = 8'd0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				src_pos_q <= {1'b0, src_bit_offset};
				dst_pos_q <= {1'b0, dst_bit_offset};
				rem_q <= bit_count;
				big_q <= big_endian;
				dst_len_q <= dst_length;
				src_len_q <= src_length;
				emit_q <= 5'd0;
			end
			ST_COPY_WR: begin
				src_pos_q <= src_pos_q + 9'd1;
				dst_pos_q <= dst_pos_q + 9'd1;
				rem_q <= rem_q - 9'd1;
			end
			ST_EMIT_OUT: begin
				emit_q <= emit_q + 5'd1;
			end
			default: begin
			end
		endcase
	end

	`BFCE_ASSERT_NOW(a_strobe_busy, strobe, busy)
	`BFCE_ASSERT_NOW(a_error_shape, error, last && (out_index == 5'd0) && (out_value == 8'd0))
	`BFCE_ASSERT_NEXT(a_last_idle, strobe && last, !busy)
	`BFCE_ASSERT_NEXT(a_run_busy, start && !busy && (mode == MODE_RUN), busy)
	`BFCE_ASSERT_NEXT(a_load_idle, start && !busy && (mode != MODE_RUN), !busy)

endmodule
